// File: hdl/cra_pkg.sv
// ----------------------------------------------------------------------------
// cra_pkg: shared definitions for the contiguous register allocator
// Field widths, opcodes, status codes, default parameters and the command
// bundle that drives the pool bitmap unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cra_pkg;

    // Default configuration
    localparam int FIRST_REG_DEF  = 16;
    localparam int LAST_REG_DEF   = 95;
    localparam int MAX_VALUES_DEF = 256;
    localparam int MAX_RUN_DEF    = 4;
    localparam int POOL_N_DEF     = LAST_REG_DEF - FIRST_REG_DEF + 1;

    // Field widths
    localparam int OP_W    = 2;
    localparam int VID_W   = 8;
    localparam int LEN_W   = 3;
    localparam int REGN_W  = 7;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 9;
    localparam int RUN_W   = 4;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Opcodes
    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEFINE  = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

    // Result status
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_ERR   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOFIT = 2'd2;

    // Commands to the pool bitmap unit
    typedef struct packed {
        logic              clear_all;
        logic              scan_restart;
        logic              scan_step;
        logic              set_bit;
        logic              clr_bit;
        logic [REGN_W-1:0] index;
        logic [RUN_W-1:0]  need;
    } pool_cmd_t;

endpackage

// File: hdl/contiguous_register_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_register_allocator: first-fit contiguous register allocator
// Sequence: lookup and release read the map, evaluate and finish; clear
//   finishes at once; define checks each of its L values, scans pool
//   positions (up to 80 with the default pool), then writes the L entries.
// Throughput: one request at a time; the next beat is taken in the cycle
//   after the result enters the output register. The pool scan dominates.
// Reset: synchronous, active low; pool free, no value mapped, high-water
//   mark at the first pool register, value count zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module contiguous_register_allocator #(
    parameter int FIRST_REG  = cra_pkg::FIRST_REG_DEF,
    parameter int LAST_REG   = cra_pkg::LAST_REG_DEF,
    parameter int MAX_VALUES = cra_pkg::MAX_VALUES_DEF,
    parameter int MAX_RUN    = cra_pkg::MAX_RUN_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request: [1:0] op, [9:2] value_id, [12:10] run_length, [15:13] zero
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cra_pkg::S_TDATA_W-1:0]   s_tdata,
    // result: [6:0] reg_number, [8:7] status, [15:9] high_water
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cra_pkg::M_TDATA_W-1:0]   m_tdata,
    // value-number count register write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cra_pkg::CNT_W-1:0]       cfg_data
);

    // Pool geometry; an empty pool never fits a run
    localparam bit POOL_EMPTY = (LAST_REG < FIRST_REG);
    localparam int POOL_N     = POOL_EMPTY ? 1 : LAST_REG - FIRST_REG + 1;
    localparam int PIW        = (POOL_N > 1) ? $clog2(POOL_N) : 1;
    localparam int VAW        = $clog2(MAX_VALUES);
    localparam int SUMW       = (VAW > 9) ? VAW : 9;
    localparam int LIVE_CAP   = (MAX_VALUES > 511) ? 511 : MAX_VALUES;
    localparam int HM_MAX     = POOL_EMPTY ? FIRST_REG : LAST_REG + 1;

    localparam int RW = cra_pkg::REGN_W;
    localparam int SW = cra_pkg::STAT_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                    state_reg, state_next;
    logic [cra_pkg::OP_W-1:0]      op_reg, op_next;
    logic [cra_pkg::VID_W-1:0]     vid_reg, vid_next;
    logic [cra_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [cra_pkg::LEN_W-1:0]     k_reg, k_next;
    logic                          in_range_reg, in_range_next;
    logic [PIW-1:0]                pos_reg, pos_next;
    logic [PIW-1:0]                start_reg, start_next;
    logic [RW-1:0]                 res_reg_reg, res_reg_next;
    logic [SW-1:0]                 res_stat_reg, res_stat_next;
    logic [7:0]                    hm_reg, hm_next;
    logic [MAX_VALUES-1:0]         valid_reg, valid_next;
    logic [cra_pkg::CNT_W-1:0]     num_values_reg;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [cra_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [VAW-1:0]                addr_q_reg, addr_q_next;

    // Request fields
    logic [cra_pkg::OP_W-1:0]  in_op;
    logic [cra_pkg::VID_W-1:0] in_vid;
    logic [cra_pkg::LEN_W-1:0] in_len;

    assign in_op  = s_tdata[1:0];
    assign in_vid = s_tdata[9:2];
    assign in_len = s_tdata[12:10];

    // Live value range and define checks at accept time
    logic [cra_pkg::CNT_W-1:0] live_w;
    logic                      in_range_w;
    logic [9:0]                run_end_w;
    logic                      def_bad_w;

    assign live_w     = (num_values_reg > cra_pkg::CNT_W'(LIVE_CAP)) ?
                        cra_pkg::CNT_W'(LIVE_CAP) : num_values_reg;
    assign in_range_w = {1'b0, in_vid} < live_w;
    assign run_end_w  = 10'(in_vid) + 10'(in_len);
    assign def_bad_w  = (in_len == '0) || (4'(in_len) > 4'(MAX_RUN)) || !in_range_w ||
                        (run_end_w > 10'(live_w));

    // Value map address: first value plus run offset
    logic [SUMW-1:0] sum_w;
    logic [VAW-1:0]  addr_w;

    assign sum_w  = SUMW'(vid_reg) + SUMW'(k_reg);
    assign addr_w = sum_w[VAW-1:0];

    // Value map storage; an entry never written since clear reads as zero
    logic          ram_we;
    logic          ram_re;
    logic [RW-1:0] ram_q;
    logic [7:0]    wr_regn_w;
    logic [RW-1:0] entry_w;

    assign wr_regn_w = 8'(FIRST_REG) + 8'(start_reg) + 8'(k_reg);
    assign entry_w   = valid_reg[addr_q_reg] ? ram_q : '0;

    cra_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_VALUES)
    ) u_value_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr_w),
        .wdata (wr_regn_w[RW-1:0]),
        .re    (ram_re),
        .raddr (addr_w),
        .rdata (ram_q)
    );

    // Pool bitmap and free-run counter
    cra_pkg::pool_cmd_t pool_cmd;
    logic               pool_hit;

    cra_pool #(
        .POOL_N (POOL_N)
    ) u_pool (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (pool_cmd),
        .hit     (pool_hit)
    );

    // Release target inside the pool, and the scan's window start
    logic [7:0] rel_off_w;
    logic       rel_in_pool_w;
    logic [7:0] start_w;
    logic [7:0] high_end_w;

    assign rel_off_w     = 8'(entry_w) - 8'(FIRST_REG);
    assign rel_in_pool_w = !POOL_EMPTY && (8'(entry_w) >= 8'(FIRST_REG)) &&
                           (rel_off_w < 8'(POOL_N));
    assign start_w       = 8'(pos_reg) - 8'(len_reg) + 8'd1;
    assign high_end_w    = 8'(FIRST_REG) + 8'(start_reg) + 8'(len_reg);

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        vid_next      = vid_reg;
        len_next      = len_reg;
        k_next        = k_reg;
        in_range_next = in_range_reg;
        pos_next      = pos_reg;
        start_next    = start_reg;
        res_reg_next  = res_reg_reg;
        res_stat_next = res_stat_reg;
        hm_next       = hm_reg;
        valid_next    = valid_reg;
        addr_q_next   = addr_q_reg;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        pool_cmd      = '0;
        pool_cmd.need = cra_pkg::RUN_W'(len_reg);
        pool_cmd.index = RW'(pos_reg);

        // drop the result once it is taken
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next       = in_op;
                    vid_next      = in_vid;
                    len_next      = in_len;
                    k_next        = '0;
                    in_range_next = in_range_w;
                    res_reg_next  = RW'(FIRST_REG);
                    res_stat_next = cra_pkg::ST_OK;
                    case (in_op)
                        cra_pkg::OP_LOOKUP,
                        cra_pkg::OP_RELEASE: begin
                            state_next = S_RD;
                        end
                        cra_pkg::OP_DEFINE: begin
                            if (def_bad_w) begin
                                res_stat_next = cra_pkg::ST_ERR;
                                state_next    = S_DONE;
                            end else begin
                                state_next = S_RD;
                            end
                        end
                        default: begin
                            // clear: wipe map, pool and high-water mark
                            valid_next         = '0;
                            hm_next            = 8'(FIRST_REG);
                            pool_cmd.clear_all = 1'b1;
                            state_next         = S_DONE;
                        end
                    endcase
                end
            end
            S_RD: begin
                ram_re      = 1'b1;
                addr_q_next = addr_w;
                state_next  = S_EVAL;
            end
            S_EVAL: begin
                case (op_reg)
                    cra_pkg::OP_LOOKUP: begin
                        if (!in_range_reg || (entry_w == '0)) begin
                            res_stat_next = cra_pkg::ST_ERR;
                        end else begin
                            res_reg_next = entry_w;
                        end
                        state_next = S_DONE;
                    end
                    cra_pkg::OP_RELEASE: begin
                        if (in_range_reg && (entry_w != '0) && rel_in_pool_w) begin
                            pool_cmd.clr_bit = 1'b1;
                            pool_cmd.index   = rel_off_w[RW-1:0];
                        end
                        state_next = S_DONE;
                    end
                    default: begin
                        if (entry_w != '0) begin
                            res_stat_next = cra_pkg::ST_ERR;
                            state_next    = S_DONE;
                        end else if ((k_reg + 3'd1) == len_reg) begin
                            if (POOL_EMPTY) begin
                                res_stat_next = cra_pkg::ST_NOFIT;
                                state_next    = S_DONE;
                            end else begin
                                pool_cmd.scan_restart = 1'b1;
                                pos_next              = '0;
                                state_next            = S_SCAN;
                            end
                        end else begin
                            k_next     = k_reg + 3'd1;
                            state_next = S_RD;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                pool_cmd.scan_step = 1'b1;
                if (pool_hit) begin
                    start_next = start_w[PIW-1:0];
                    k_next     = '0;
                    state_next = S_WRITE;
                end else if (pos_reg == PIW'(POOL_N - 1)) begin
                    res_stat_next = cra_pkg::ST_NOFIT;
                    state_next    = S_DONE;
                end else begin
                    pos_next = pos_reg + PIW'(1);
                end
            end
            S_WRITE: begin
                ram_we             = 1'b1;
                valid_next[addr_w] = 1'b1;
                pool_cmd.set_bit   = 1'b1;
                pool_cmd.index     = RW'(start_reg) + RW'(k_reg);
                if ((k_reg + 3'd1) == len_reg) begin
                    if (high_end_w > hm_reg) begin
                        hm_next = high_end_w;
                    end
                    res_reg_next = RW'(8'(FIRST_REG) + 8'(start_reg));
                    state_next   = S_DONE;
                end else begin
                    k_next = k_reg + 3'd1;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {hm_reg[RW-1:0], res_stat_reg, res_reg_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            hm_reg         <= 8'(FIRST_REG);
            valid_reg      <= '0;
            num_values_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            hm_reg       <= hm_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                num_values_reg <= cfg_data;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        vid_reg      <= vid_next;
        len_reg      <= len_next;
        k_reg        <= k_next;
        in_range_reg <= in_range_next;
        pos_reg      <= pos_next;
        start_reg    <= start_next;
        res_reg_reg  <= res_reg_next;
        res_stat_reg <= res_stat_next;
        addr_q_reg   <= addr_q_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    logic acc_clear_w;

    assign acc_clear_w = s_tvalid && s_tready && (in_op == cra_pkg::OP_CLEAR);

    // high-water mark only moves down on a clear
    a_hm_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        !acc_clear_w |=> hm_reg >= $past(hm_reg))
        else $error("high-water mark decreased without a clear");

    // high-water mark stays within the pool bounds
    a_hm_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (hm_reg >= 8'(FIRST_REG)) && (hm_reg <= 8'(HM_MAX)))
        else $error("high-water mark out of pool bounds");

    // only a define can report that no run fits
    a_nofit_define: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) && (res_stat_reg == cra_pkg::ST_NOFIT)
        |-> op_reg == cra_pkg::OP_DEFINE)
        else $error("no-fit status on a request other than define");

    // a map write only begins out of a pool scan
    a_write_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE) && (k_reg == '0) |-> $past(state_reg) == S_SCAN)
        else $error("map write entered without a pool scan");

endmodule

// File: hdl/cra_ram.sv
// ----------------------------------------------------------------------------
// cra_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/cra_pool.sv
// ----------------------------------------------------------------------------
// cra_pool: register pool busy bitmap with free-run counter
// Holds one busy bit per pool register and counts consecutive free
// positions, one position per scan step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cra_pool #(
    parameter int POOL_N = cra_pkg::POOL_N_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cra_pkg::pool_cmd_t cmd,
    output logic              hit
);

    localparam int PIW = (POOL_N > 1) ? $clog2(POOL_N) : 1;

    logic [POOL_N-1:0]           busy_reg, busy_next;
    logic [cra_pkg::RUN_W-1:0]   run_reg, run_next;
    logic [PIW-1:0]              idx;
    logic                        free;
    logic [cra_pkg::RUN_W-1:0]   run_inc;

    assign idx     = cmd.index[PIW-1:0];
    assign free    = !busy_reg[idx];
    assign run_inc = run_reg + cra_pkg::RUN_W'(1);
    assign hit     = cmd.scan_step && free && (run_inc == cmd.need);

    always_comb begin
        busy_next = busy_reg;
        run_next  = run_reg;
        if (cmd.clear_all) begin
            busy_next = '0;
        end else if (cmd.set_bit) begin
            busy_next[idx] = 1'b1;
        end else if (cmd.clr_bit) begin
            busy_next[idx] = 1'b0;
        end
        // count consecutive free positions; any busy one restarts the run
        if (cmd.scan_restart) begin
            run_next = '0;
        end else if (cmd.scan_step) begin
            run_next = free ? run_inc : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= '0;
            run_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            run_reg  <= run_next;
        end
    end

endmodule

// File: bench/contiguous_register_allocator_tb.sv
// ----------------------------------------------------------------------------
// contiguous_register_allocator_tb: self-checking bench for the allocator
// Drives lookup, define, release and clear requests on the request stream.
// It tracks the busy bitmap, the value map and the high-water mark in its own
// copy and checks every result beat field by field against that copy.
// Directed cases come first, then random traffic over several value counts.
// Both stream sides take random stall bursts, except in the phases run without idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module contiguous_register_allocator_tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 20;

    // One result beat: [6:0] reg_number, [8:7] status, [15:9] high_water
    typedef struct packed {
        logic [cra_pkg::REGN_W-1:0] high_water;
        logic [cra_pkg::STAT_W-1:0] status;
        logic [cra_pkg::REGN_W-1:0] reg_no;
    } alloc_result_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    // [1:0] op, [9:2] value_id, [12:10] run_length
    logic [cra_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    // [6:0] reg_number, [8:7] status, [15:9] high_water
    logic [cra_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [cra_pkg::CNT_W-1:0]     cfg_data  = '0;

    // Shadow copy of the allocator state
    bit                         pool_busy [cra_pkg::POOL_N_DEF];
    logic [cra_pkg::REGN_W-1:0] value_map [cra_pkg::MAX_VALUES_DEF];
    logic [cra_pkg::REGN_W-1:0] high_mark;
    logic [cra_pkg::CNT_W-1:0]  num_values;

    alloc_result_t        pending_results[$];
    int                   mismatch_count = 0;
    int                   cycle_count    = 0;
    int                   stall_left     = 0;
    bit                   idling_on      = 1'b1;

    contiguous_register_allocator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Shadow state helpers
    // ------------------------------------------------------------------------

    // Forget every mapping and free the whole pool; the value count survives.
    function automatic void wipe_allocations();
        foreach (pool_busy[i]) pool_busy[i] = 1'b0;
        foreach (value_map[i]) value_map[i] = '0;
        high_mark = cra_pkg::REGN_W'(cra_pkg::FIRST_REG_DEF);
    endfunction

    // Counts above the value table size behave as the table size.
    function automatic int live_limit();
        return (int'(num_values) > cra_pkg::MAX_VALUES_DEF) ?
               cra_pkg::MAX_VALUES_DEF : int'(num_values);
    endfunction

    // Apply one request to the shadow state and return the result it yields.
    function automatic alloc_result_t alloc_predict(logic [cra_pkg::OP_W-1:0] op,
                                                    logic [cra_pkg::VID_W-1:0] vid,
                                                    logic [cra_pkg::LEN_W-1:0] len);
        alloc_result_t res;
        int lim, v, n, pos, k, r;
        bit taken, fits;
        res.reg_no = cra_pkg::REGN_W'(cra_pkg::FIRST_REG_DEF);
        res.status = cra_pkg::ST_OK;
        lim = live_limit();
        v = int'(vid);
        n = int'(len);
        case (op)
            cra_pkg::OP_LOOKUP: begin
                if (v >= lim || value_map[v] == '0)
                    res.status = cra_pkg::ST_ERR;
                else
                    res.reg_no = value_map[v];
            end
            cra_pkg::OP_DEFINE: begin
                if (n == 0 || n > cra_pkg::MAX_RUN_DEF || v >= lim || n > lim - v) begin
                    res.status = cra_pkg::ST_ERR;
                end else begin
                    taken = 1'b0;
                    for (k = 0; k < n; k++)
                        if (value_map[v + k] != '0) taken = 1'b1;
                    if (taken) begin
                        res.status = cra_pkg::ST_ERR;
                    end else begin
                        // first-fit scan from the bottom of the pool
                        res.status = cra_pkg::ST_NOFIT;
                        for (pos = 0; pos + n <= cra_pkg::POOL_N_DEF &&
                             res.status == cra_pkg::ST_NOFIT; pos++) begin
                            fits = 1'b1;
                            for (k = 0; k < n; k++)
                                if (pool_busy[pos + k]) fits = 1'b0;
                            if (fits) begin
                                for (k = 0; k < n; k++) begin
                                    pool_busy[pos + k] = 1'b1;
                                    value_map[v + k] = cra_pkg::REGN_W'(
                                        cra_pkg::FIRST_REG_DEF + pos + k);
                                end
                                if (cra_pkg::FIRST_REG_DEF + pos + n > int'(high_mark))
                                    high_mark = cra_pkg::REGN_W'(
                                        cra_pkg::FIRST_REG_DEF + pos + n);
                                res.status = cra_pkg::ST_OK;
                                res.reg_no = cra_pkg::REGN_W'(cra_pkg::FIRST_REG_DEF + pos);
                            end
                        end
                    end
                end
            end
            cra_pkg::OP_RELEASE: begin
                // the mapping stays; only the register goes back to the pool
                if (v < lim && value_map[v] != '0) begin
                    r = int'(value_map[v]);
                    if (r >= cra_pkg::FIRST_REG_DEF &&
                        r - cra_pkg::FIRST_REG_DEF < cra_pkg::POOL_N_DEF)
                        pool_busy[r - cra_pkg::FIRST_REG_DEF] = 1'b0;
                end
            end
            default: wipe_allocations();
        endcase
        res.high_water = high_mark;
        return res;
    endfunction

    // Pick a value in range whose run of len entries is all mapped or all free.
    function automatic int pick_value(bit mapped, int len);
        int lim, v, k, t;
        bit ok;
        lim = live_limit();
        v = $urandom_range(0, 255);
        if (lim < len) return v;
        for (t = 0; t < 12; t++) begin
            v = $urandom_range(0, lim - len);
            ok = 1'b1;
            for (k = 0; k < len; k++)
                if ((value_map[v + k] != '0) != mapped) ok = 1'b0;
            if (ok) return v;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------------

    // Send one request beat; predict its result at the accepting edge.
    // Valid stays high across back-to-back beats and drops only for a gap.
    task automatic send_request(logic [cra_pkg::OP_W-1:0] op,
                                logic [cra_pkg::VID_W-1:0] vid,
                                logic [cra_pkg::LEN_W-1:0] len);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tdata  <= {3'b000, len, vid, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(alloc_predict(op, vid, len));
    endtask

    // Hold off the request side until every predicted result has come back.
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Write the value count while the block is idle.
    task automatic write_num_values(logic [cra_pkg::CNT_W-1:0] cnt);
        wait_results_done();
        repeat (4) @(posedge aclk);
        cfg_data  <= cnt;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        num_values  = cnt;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // The count is zero out of reset: every value is out of range.
    task automatic test_zero_count();
        send_request(cra_pkg::OP_LOOKUP,  8'd0, 3'd0);
        send_request(cra_pkg::OP_DEFINE,  8'd0, 3'd1);
        send_request(cra_pkg::OP_RELEASE, 8'd0, 3'd0);
    endtask

    task automatic test_directed_ops();
        write_num_values(9'd256);
        send_request(cra_pkg::OP_DEFINE,  8'd0,   3'd1);   // first register of the pool
        send_request(cra_pkg::OP_DEFINE,  8'd1,   3'd4);   // longest run right after it
        send_request(cra_pkg::OP_DEFINE,  8'd0,   3'd1);   // redefinition of a single value
        send_request(cra_pkg::OP_DEFINE,  8'd3,   3'd2);   // run overlaps defined values
        send_request(cra_pkg::OP_DEFINE,  8'd10,  3'd0);   // empty run
        send_request(cra_pkg::OP_DEFINE,  8'd10,  3'd5);   // run one past the maximum
        send_request(cra_pkg::OP_DEFINE,  8'd10,  3'd7);   // all length bits set
        send_request(cra_pkg::OP_DEFINE,  8'd255, 3'd1);   // top value
        send_request(cra_pkg::OP_DEFINE,  8'd254, 3'd4);   // run reaching past the count
        send_request(cra_pkg::OP_DEFINE,  8'd250, 3'd4);
        send_request(cra_pkg::OP_LOOKUP,  8'd255, 3'd7);
        send_request(cra_pkg::OP_LOOKUP,  8'd100, 3'd0);   // never defined
        send_request(cra_pkg::OP_RELEASE, 8'd0,   3'd0);
        send_request(cra_pkg::OP_RELEASE, 8'd0,   3'd0);   // second release does nothing
        send_request(cra_pkg::OP_LOOKUP,  8'd0,   3'd0);   // mapping kept after release
        send_request(cra_pkg::OP_DEFINE,  8'd0,   3'd1);   // released value is still defined
        send_request(cra_pkg::OP_RELEASE, 8'd200, 3'd0);   // release of an undefined value
        send_request(cra_pkg::OP_DEFINE,  8'd20,  3'd1);   // reuses the freed register
        send_request(cra_pkg::OP_CLEAR,   8'd170, 3'd2);
        send_request(cra_pkg::OP_LOOKUP,  8'd1,   3'd0);   // gone after the clear
    endtask

    // Counts above the table size clamp; a tiny count hides mapped values.
    task automatic test_count_extremes();
        write_num_values(9'd511);
        send_request(cra_pkg::OP_DEFINE, 8'd252, 3'd4);
        send_request(cra_pkg::OP_DEFINE, 8'd253, 3'd4);
        write_num_values(9'd1);
        send_request(cra_pkg::OP_DEFINE, 8'd0,   3'd2);
        send_request(cra_pkg::OP_LOOKUP, 8'd252, 3'd0);
    endtask

    // Mostly well-formed traffic with random content, some noise on top.
    // Pause once halfway to let the result queue run dry.
    task automatic test_random_traffic(logic [cra_pkg::CNT_W-1:0] cnt, int items,
                                       int define_pct, int clear_pct, bit fresh, bit idle);
        int i, pick, len;
        write_num_values(cnt);
        idling_on = idle;
        if (fresh) send_request(cra_pkg::OP_CLEAR, 8'($urandom), 3'($urandom));
        for (i = 0; i < items; i++) begin
            if (i == items / 2) wait_results_done();
            pick = $urandom_range(0, 99);
            if (pick < define_pct) begin
                len = $urandom_range(1, cra_pkg::MAX_RUN_DEF);
                send_request(cra_pkg::OP_DEFINE, 8'(pick_value(1'b0, len)), 3'(len));
            end else if (pick < define_pct + 20) begin
                send_request(cra_pkg::OP_LOOKUP, 8'(pick_value(1'b1, 1)), 3'($urandom));
            end else if (pick < define_pct + 35) begin
                send_request(cra_pkg::OP_RELEASE, 8'(pick_value(1'b1, 1)), 3'($urandom));
            end else if (pick < define_pct + 35 + clear_pct) begin
                send_request(cra_pkg::OP_CLEAR, 8'($urandom), 3'($urandom));
            end else begin
                send_request(2'($urandom), 8'($urandom), 3'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: check each beat, then pick the next ready level
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        alloc_result_t seen, want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = m_tdata;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat with none expected, actual %h", $time, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (seen.reg_no != want.reg_no) begin
                    mismatch_count++;
                    $display("%0t: reg_number expected %0d actual %0d",
                             $time, want.reg_no, seen.reg_no);
                end
                if (seen.status != want.status) begin
                    mismatch_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, seen.status);
                end
                if (seen.high_water != want.high_water) begin
                    mismatch_count++;
                    $display("%0t: high_water expected %0d actual %0d",
                             $time, want.high_water, seen.high_water);
                end
            end
        end
        // random stall bursts while idling is enabled
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= (stall_left == 0);
        end else if (idling_on && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 19);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run if the traffic never drains.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        wipe_allocations();
        num_values = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_zero_count();
        test_directed_ops();
        test_count_extremes();
        test_random_traffic(9'd256, 300, 45, 2, 1'b1, 1'b1);
        test_random_traffic(9'd256, 200, 65, 0, 1'b1, 1'b1);  // fill the pool
        test_random_traffic(9'd40,  200, 45, 3, 1'b0, 1'b0);  // shrink, no idling
        test_random_traffic(9'd511, 260, 50, 2, 1'b1, 1'b1);
        test_random_traffic(9'd5,   150, 45, 4, 1'b0, 1'b1);
        test_random_traffic(9'd256, 220, 50, 2, 1'b1, 1'b0);  // final phase, no idling

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
